[hw/rtl/multiturn_encoder_tracker_macros.svh]
// Assertion macros used by the tracker checker.
`ifndef MULTITURN_ENCODER_TRACKER_MACROS_SVH
`define MULTITURN_ENCODER_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mte_pkg.sv]
// Constants, widths and register indexes for the multi-turn encoder tracker.
package mte_pkg;

    localparam int DEF_BLOCK        = 8;
    localparam int DEF_ENCODER_BITS = 13;

    localparam int SCALE_W  = 24;
    localparam int CALMSG_W = 8;
    localparam int TURN_W   = 24;
    localparam int CONT_W   = 37;
    localparam int ANGLE_W  = 48;
    localparam int RATE_W   = 14;
    localparam int SEEN_W   = 8;

    localparam logic [SCALE_W-1:0]  DEF_DEG_PER_COUNT = 24'd38804;
    localparam logic [CALMSG_W-1:0] DEF_CAL_MESSAGES  = 8'd50;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 24'sh7FFFFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 24'sh800000;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SCALE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEG_PER_COUNT = 1'b0,
        CFG_CAL_MESSAGES  = 1'b1
    } t_cfg_idx;

endpackage

[hw/rtl/multiturn_encoder_tracker.sv]
// Multi-turn encoder tracker: calibration, unwrap, turn count, scaled angle, block mean.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | sink      | i_in_valid / o_in_ready   | i_raw_angle
//  out     | source    | o_out_valid / i_out_ready | calibrating .. mean_updated
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One beat per cycle in and out unless the output stalls. Results come from
//  a six-register pipeline, the angle path split into two partial products of the
//  38-bit count magnitude by the 24-bit scale. Tracker state updates at the input beat.
//  Each stage moves when the next one is empty or moving, so bubbles absorb stalls.
//  Synchronous active-low reset clears state, config to defaults, and all valid bits.
module multiturn_encoder_tracker #(
    parameter int BLOCK        = mte_pkg::DEF_BLOCK,
    parameter int ENCODER_BITS = mte_pkg::DEF_ENCODER_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ENCODER_BITS-1:0]               i_raw_angle,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_calibrating,
    output logic signed [mte_pkg::TURN_W-1:0]     o_turn_count,
    output logic signed [mte_pkg::CONT_W-1:0]     o_continuous_count,
    output logic signed [mte_pkg::ANGLE_W-1:0]    o_angle_q8,
    output logic signed [mte_pkg::RATE_W-1:0]     o_step_rate,
    output logic signed [mte_pkg::RATE_W-1:0]     o_mean_rate,
    output logic                                  o_mean_updated,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mte_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mte_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import mte_pkg::*;

    localparam int EB       = ENCODER_BITS;
    localparam int RATE_IW  = EB + 1;
    localparam int SUM_W    = EB + 1 + $clog2(BLOCK);
    localparam int FILL_W   = (BLOCK > 1) ? $clog2(BLOCK) : 1;
    localparam int DELTA_W  = TURN_W + EB + 1;
    localparam int LO_W     = 18;
    localparam int HI_W     = DELTA_W - LO_W;
    localparam int PLO_W    = LO_W + SCALE_W;
    localparam int PHI_W    = HI_W + SCALE_W;
    localparam int PROD_W   = DELTA_W + SCALE_W;
    localparam int QUO_W    = PROD_W - 16;
    localparam int ANG_IW   = QUO_W + 1;
    localparam int RECIP_SH = SUM_W + $clog2(BLOCK);
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int MPROD_W  = SUM_W + RECIP_W;
    localparam int NSTG     = 6;

    localparam logic signed [RATE_IW-1:0] HALF_TURN = RATE_IW'(longint'(1) << (EB - 1));
    localparam logic signed [RATE_IW-1:0] FULL_TURN = RATE_IW'(longint'(1) << EB);
    localparam logic [FILL_W-1:0]         FILL_LAST = FILL_W'(BLOCK - 1);
    // ceil(2^RECIP_SH / BLOCK): exact quotient for every sum magnitude
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << RECIP_SH) + longint'(BLOCK) - 1) / longint'(BLOCK));

    // configuration
    logic [SCALE_W-1:0]  r_scale;
    logic [CALMSG_W-1:0] r_cal_msgs;

    // tracker state
    logic [EB-1:0]              r_bias;
    logic [EB-1:0]              r_prev;
    logic signed [TURN_W-1:0]   r_turns;
    logic signed [SUM_W-1:0]    r_sum;
    logic [FILL_W-1:0]          r_fill;
    logic [SEEN_W-1:0]          r_seen;
    logic signed [RATE_IW-1:0]  r_mean;

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;
    logic            w_in_fire;

    // stage 0
    logic                       r0_calib, r0_upd;
    logic signed [TURN_W-1:0]   r0_turns;
    logic [EB-1:0]              r0_raw, r0_bias;
    logic signed [RATE_IW-1:0]  r0_rate;
    logic signed [SUM_W-1:0]    r0_sum;
    // stage 1
    logic                       r1_calib, r1_upd, r1_sum_neg;
    logic signed [TURN_W-1:0]   r1_turns;
    logic [EB-1:0]              r1_raw;
    logic signed [RATE_IW-1:0]  r1_rate;
    logic signed [DELTA_W-1:0]  r1_delta;
    logic [SUM_W-1:0]           r1_sum_mag;
    // stage 2
    logic                       r2_calib, r2_upd, r2_sum_neg, r2_neg;
    logic signed [TURN_W-1:0]   r2_turns;
    logic [EB-1:0]              r2_raw;
    logic signed [RATE_IW-1:0]  r2_rate;
    logic [DELTA_W-1:0]         r2_mag;
    logic [MPROD_W-1:0]         r2_mprod;
    // stage 3
    logic                       r3_calib, r3_upd, r3_neg;
    logic signed [TURN_W-1:0]   r3_turns;
    logic [EB-1:0]              r3_raw;
    logic signed [RATE_IW-1:0]  r3_rate, r3_mean;
    logic [PLO_W-1:0]           r3_plo;
    logic [PHI_W-1:0]           r3_phi;
    // stage 4
    logic                       r4_calib, r4_upd, r4_neg, r4_lownz;
    logic signed [TURN_W-1:0]   r4_turns;
    logic [EB-1:0]              r4_raw;
    logic signed [RATE_IW-1:0]  r4_rate, r4_mean;
    logic [PROD_W-1:0]          r4_prod;
    // stage 5, output register
    logic                       r5_calib, r5_upd;
    logic signed [TURN_W-1:0]   r5_turns;
    logic [EB-1:0]              r5_raw;
    logic signed [RATE_IW-1:0]  r5_rate, r5_mean;
    logic signed [ANG_IW-1:0]   r5_angle;

    // input-side next values
    logic                       n_calib, n_last;
    logic signed [RATE_IW-1:0]  n_diff, n_rate;
    logic signed [TURN_W-1:0]   n_turns;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [RATE_IW-1:0]  n_mean;
    logic [QUO_W-1:0]           n_quo;
    logic signed [ANG_IW-1:0]   n_quo_s, n_angle;

    // ---------------- handshake ----------------
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_in_ready  = w_adv[0];
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_vld[NSTG-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= (k == 0) ? w_in_fire : r_vld[(k > 0) ? k - 1 : 0];
                end
            end
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= DEF_DEG_PER_COUNT;
            r_cal_msgs <= DEF_CAL_MESSAGES;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEG_PER_COUNT: r_scale    <= i_cfg_data[SCALE_W-1:0];
                CFG_CAL_MESSAGES:  r_cal_msgs <= i_cfg_data[CALMSG_W-1:0];
            endcase
        end
    end

    // ---------------- unwrap and state update ----------------
    always_comb begin
        n_calib = r_seen < SEEN_W'(r_cal_msgs);
        n_diff  = RATE_IW'({1'b0, i_raw_angle} - {1'b0, r_prev});
        n_turns = r_turns;
        // rate always lands within half a turn, so the add/sub may wrap at RATE_IW bits
        if (n_diff < -HALF_TURN) begin
            n_rate = n_diff + FULL_TURN;
            if (r_turns != TURN_MAX) n_turns = r_turns + TURN_W'(1);
        end else if (n_diff > HALF_TURN) begin
            n_rate = n_diff - FULL_TURN;
            if (r_turns != TURN_MIN) n_turns = r_turns - TURN_W'(1);
        end else begin
            n_rate = n_diff;
        end
        n_sum  = r_sum + SUM_W'(n_rate);
        n_last = r_fill == FILL_LAST;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias  <= '0;
            r_prev  <= '0;
            r_turns <= '0;
            r_sum   <= '0;
            r_fill  <= '0;
            r_seen  <= '0;
        end else if (w_in_fire) begin
            if (r_seen != '1) r_seen <= r_seen + SEEN_W'(1);
            r_prev <= i_raw_angle;
            if (n_calib) begin
                r_bias <= i_raw_angle;
            end else begin
                r_turns <= n_turns;
                r_sum   <= n_last ? '0 : n_sum;
                r_fill  <= n_last ? '0 : r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_calib <= n_calib;
            r0_upd   <= !n_calib && n_last;
            r0_turns <= n_calib ? r_turns : n_turns;
            r0_raw   <= i_raw_angle;
            r0_bias  <= n_calib ? i_raw_angle : r_bias;
            r0_rate  <= n_calib ? '0 : n_rate;
            r0_sum   <= n_sum;
        end
    end

    // ---------------- stage 1: count from bias, sum magnitude ----------------
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_calib   <= r0_calib;
            r1_upd     <= r0_upd;
            r1_turns   <= r0_turns;
            r1_raw     <= r0_raw;
            r1_rate    <= r0_rate;
            r1_delta   <= DELTA_W'(signed'({r0_turns, {EB{1'b0}}}))
                        + DELTA_W'(signed'({1'b0, r0_raw} - {1'b0, r0_bias}));
            r1_sum_neg <= r0_sum[SUM_W-1];
            r1_sum_mag <= r0_sum[SUM_W-1] ? SUM_W'(-r0_sum) : SUM_W'(r0_sum);
        end
    end

    // ---------------- stage 2: magnitude, mean reciprocal product ----------------
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_calib   <= r1_calib;
            r2_upd     <= r1_upd;
            r2_turns   <= r1_turns;
            r2_raw     <= r1_raw;
            r2_rate    <= r1_rate;
            r2_neg     <= r1_delta[DELTA_W-1];
            r2_mag     <= r1_delta[DELTA_W-1] ? DELTA_W'(-r1_delta) : DELTA_W'(r1_delta);
            r2_sum_neg <= r1_sum_neg;
            r2_mprod   <= MPROD_W'(r1_sum_mag) * MPROD_W'(RECIP);
        end
    end

    // ---------------- stage 3: partial products, block mean ----------------
    always_comb begin
        n_mean = RATE_IW'(r2_mprod >> RECIP_SH);
        if (r2_sum_neg) n_mean = -n_mean;
        if (!r2_upd) n_mean = r_mean;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
        end else if (w_adv[3] && r_vld[2] && r2_upd) begin
            r_mean <= n_mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_calib <= r2_calib;
            r3_upd   <= r2_upd;
            r3_turns <= r2_turns;
            r3_raw   <= r2_raw;
            r3_rate  <= r2_rate;
            r3_mean  <= n_mean;
            r3_neg   <= r2_neg;
            r3_plo   <= PLO_W'(r2_mag[LO_W-1:0]) * PLO_W'(r_scale);
            r3_phi   <= PHI_W'(r2_mag[DELTA_W-1:LO_W]) * PHI_W'(r_scale);
        end
    end

    // ---------------- stage 4: combine partial products ----------------
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_calib <= r3_calib;
            r4_upd   <= r3_upd;
            r4_turns <= r3_turns;
            r4_raw   <= r3_raw;
            r4_rate  <= r3_rate;
            r4_mean  <= r3_mean;
            r4_neg   <= r3_neg;
            // low 16 product bits come only from the low partial product
            r4_lownz <= |r3_plo[15:0];
            r4_prod  <= (PROD_W'(r3_phi) << LO_W) + PROD_W'(r3_plo);
        end
    end

    // ---------------- stage 5: Q8 shift, floor for negative ----------------
    always_comb begin
        n_quo   = r4_prod[PROD_W-1:16];
        n_quo_s = signed'({1'b0, n_quo});
        if (!r4_neg)       n_angle = n_quo_s;
        else if (r4_lownz) n_angle = ~n_quo_s;   // -(q + 1)
        else               n_angle = -n_quo_s;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r5_calib <= r4_calib;
            r5_upd   <= r4_upd;
            r5_turns <= r4_turns;
            r5_raw   <= r4_raw;
            r5_rate  <= r4_rate;
            r5_mean  <= r4_mean;
            r5_angle <= n_angle;
        end
    end

    assign o_calibrating      = r5_calib;
    assign o_turn_count       = r5_turns;
    assign o_continuous_count = CONT_W'(signed'({r5_turns, r5_raw}));
    assign o_angle_q8         = ANGLE_W'(r5_angle);
    assign o_step_rate        = RATE_W'(r5_rate);
    assign o_mean_rate        = RATE_W'(r5_mean);
    assign o_mean_updated     = r5_upd;

endmodule

[hw/rtl/mte_checker.sv]
// Port-level checker for the multi-turn encoder tracker, bound to the top level.
`include "multiturn_encoder_tracker_macros.svh"

module mte_checker #(
    parameter int ENCODER_BITS = mte_pkg::DEF_ENCODER_BITS
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic                               o_calibrating,
    input logic signed [mte_pkg::TURN_W-1:0]  o_turn_count,
    input logic signed [mte_pkg::CONT_W-1:0]  o_continuous_count,
    input logic signed [mte_pkg::ANGLE_W-1:0] o_angle_q8,
    input logic signed [mte_pkg::RATE_W-1:0]  o_step_rate,
    input logic                               o_mean_updated
);
    import mte_pkg::*;

    localparam int HI_W = CONT_W - ENCODER_BITS;

    // a bias-capture beat never closes a block
    `MTE_ASSERT_NOW(a_calib_no_mean, o_out_valid && o_calibrating, !o_mean_updated,
        "mean refreshed on a calibrating beat")

    `MTE_ASSERT_NOW(a_calib_no_rate, o_out_valid && o_calibrating, o_step_rate == '0,
        "nonzero step rate on a calibrating beat")

    // upper bits of the continuous count are the turn count
    `MTE_ASSERT_NOW(a_turns_match, o_out_valid,
        o_continuous_count[CONT_W-1:ENCODER_BITS] == HI_W'(o_turn_count),
        "continuous count disagrees with turn count")

    `MTE_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_angle_q8) && $stable(o_turn_count),
        "result beat changed while stalled")

endmodule

bind multiturn_encoder_tracker mte_checker #(.ENCODER_BITS(ENCODER_BITS)) u_mte_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for multiturn_encoder_tracker: stream driver, monitor, unwrap predictor.
`timescale 1ns / 1ps

module tb_top;
    import mte_pkg::*;

    localparam int     BLOCK_LEN   = DEF_BLOCK;
    localparam longint FULL_TURN   = longint'(1) << DEF_ENCODER_BITS;
    localparam int     HALF_TURN   = 1 << (DEF_ENCODER_BITS - 1);
    localparam int     STALL_LIMIT = 2000;
    localparam int     PRINT_CAP   = 100;

    typedef struct packed {
        logic                      calibrating;
        logic signed [TURN_W-1:0]  turn_count;
        logic signed [CONT_W-1:0]  continuous_count;
        logic signed [ANGLE_W-1:0] angle_q8;
        logic signed [RATE_W-1:0]  step_rate;
        logic signed [RATE_W-1:0]  mean_rate;
        logic                      mean_updated;
    } t_tracker_result;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [DEF_ENCODER_BITS-1:0]   raw_angle = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          out_calibrating;
    logic signed [TURN_W-1:0]      out_turn_count;
    logic signed [CONT_W-1:0]      out_continuous_count;
    logic signed [ANGLE_W-1:0]     out_angle_q8;
    logic signed [RATE_W-1:0]      out_step_rate;
    logic signed [RATE_W-1:0]      out_mean_rate;
    logic                          out_mean_updated;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    t_cfg_idx                      cfg_index = CFG_DEG_PER_COUNT;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    // predictor copy of the tracker state and registers
    logic [SCALE_W-1:0]            scale_q24 = DEF_DEG_PER_COUNT;
    logic [CALMSG_W-1:0]           cal_msgs = DEF_CAL_MESSAGES;
    logic [DEF_ENCODER_BITS-1:0]   bias_pos = '0;
    logic [DEF_ENCODER_BITS-1:0]   last_pos = '0;
    logic signed [TURN_W-1:0]      turn_cnt = '0;
    int                            rate_acc = 0;
    int                            fill_cnt = 0;
    int                            mean_hold = 0;
    logic [SEEN_W-1:0]             seen_cnt = '0;

    logic [DEF_ENCODER_BITS-1:0]   angle_q[$];
    t_tracker_result               tracker_results_q[$];
    t_tracker_result               want_res;
    t_tracker_result               new_res;
    int                            items_left = 0;
    int                            err_cnt = 0;
    int                            result_idx = 0;
    int                            stall_cycles = 0;
    int                            walk_pos = 0;
    logic                          in_beat = 1'b0;
    logic                          calm = 1'b0;

    multiturn_encoder_tracker uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_raw_angle        (raw_angle),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_calibrating      (out_calibrating),
        .o_turn_count       (out_turn_count),
        .o_continuous_count (out_continuous_count),
        .o_angle_q8         (out_angle_q8),
        .o_step_rate        (out_step_rate),
        .o_mean_rate        (out_mean_rate),
        .o_mean_updated     (out_mean_updated),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_cnt++;
        // keep the log short when everything goes wrong
        if (err_cnt <= PRINT_CAP)
            $display("tb_top: %s mismatch at result %0d: got 'h%0h, want 'h%0h",
                     what, result_idx, got, want);
    endtask

    task automatic unwrap_reading(input logic [DEF_ENCODER_BITS-1:0] raw,
                                  output t_tracker_result res);
        int     diff;
        int     rate;
        longint delta;
        logic   calib;
        logic   updated;
        calib   = seen_cnt < cal_msgs;
        rate    = 0;
        updated = 1'b0;
        if (seen_cnt != '1)
            seen_cnt++;
        if (calib) begin
            bias_pos = raw;
            last_pos = raw;
        end else begin
            diff     = int'(raw) - int'(last_pos);
            last_pos = raw;
            // exactly half a turn either way is a plain step
            if (diff < -HALF_TURN) begin
                if (turn_cnt != TURN_MAX)
                    turn_cnt++;
                rate = diff + int'(FULL_TURN);
            end else if (diff > HALF_TURN) begin
                if (turn_cnt != TURN_MIN)
                    turn_cnt--;
                rate = diff - int'(FULL_TURN);
            end else begin
                rate = diff;
            end
            rate_acc += rate;
            fill_cnt++;
            if (fill_cnt >= BLOCK_LEN) begin
                mean_hold = rate_acc / BLOCK_LEN;  // truncates toward zero
                rate_acc  = 0;
                fill_cnt  = 0;
                updated   = 1'b1;
            end
        end
        delta = longint'(raw) - longint'(bias_pos) + longint'(turn_cnt) * FULL_TURN;
        res.calibrating      = calib;
        res.turn_count       = turn_cnt;
        res.continuous_count = CONT_W'(longint'(raw) + longint'(turn_cnt) * FULL_TURN);
        res.angle_q8         = ANGLE_W'((delta * longint'(scale_q24)) >>> 16);  // floor
        res.step_rate        = RATE_W'(rate);
        res.mean_rate        = RATE_W'(mean_hold);
        res.mean_updated     = updated;
    endtask

    // input stream: next beat at the falling edge once the current one is taken
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_beat) begin
            if (angle_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
                in_valid  <= 1'b1;
                raw_angle <= angle_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 12);
    end

    always @(posedge clk) begin
        in_beat = rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_DEG_PER_COUNT)
                    scale_q24 = cfg_data[SCALE_W-1:0];
                else
                    cal_msgs = cfg_data[CALMSG_W-1:0];
            end
            if (in_beat) begin
                unwrap_reading(raw_angle, new_res);
                tracker_results_q.push_back(new_res);
                items_left--;
            end
            if (out_valid && out_ready) begin
                if (tracker_results_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, '0);
                end else begin
                    want_res = tracker_results_q.pop_front();
                    if (out_calibrating !== want_res.calibrating)
                        report_mismatch("calibrating", out_calibrating,
                                        want_res.calibrating);
                    if (out_turn_count !== want_res.turn_count)
                        report_mismatch("turn_count", out_turn_count, want_res.turn_count);
                    if (out_continuous_count !== want_res.continuous_count)
                        report_mismatch("continuous_count", out_continuous_count,
                                        want_res.continuous_count);
                    if (out_angle_q8 !== want_res.angle_q8)
                        report_mismatch("angle_q8", out_angle_q8, want_res.angle_q8);
                    if (out_step_rate !== want_res.step_rate)
                        report_mismatch("step_rate", out_step_rate, want_res.step_rate);
                    if (out_mean_rate !== want_res.mean_rate)
                        report_mismatch("mean_rate", out_mean_rate, want_res.mean_rate);
                    if (out_mean_updated !== want_res.mean_updated)
                        report_mismatch("mean_updated", out_mean_updated,
                                        want_res.mean_updated);
                end
                result_idx++;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("tb_top: no beat for %0d cycles", STALL_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        logic [CFG_DATA_W-1:0] word;
        word = data;
        // bits above the count field are don't-care
        if (idx == CFG_CAL_MESSAGES)
            word[CFG_DATA_W-1:CALMSG_W] = (CFG_DATA_W - CALMSG_W)'($urandom);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_angle(input int pos);
        angle_q.push_back(pos[DEF_ENCODER_BITS-1:0]);
        items_left++;
    endtask

    task automatic drain();
        while (items_left != 0 || tracker_results_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // rotor walk: mostly drifting small steps, some near-half-turn and wrap jumps,
    // some readings at random
    task automatic run_walk(input int count, input int drift);
        int pick;
        int step;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            step = 0;
            if (pick < 60) begin
                step = drift + int'($urandom_range(600)) - 300;
            end else if (pick < 75) begin
                step = int'($urandom_range(HALF_TURN + 4, HALF_TURN - 6));
                if ($urandom_range(1)) step = -step;
            end else if (pick < 85) begin
                step = int'($urandom_range(int'(FULL_TURN) - 1, int'(FULL_TURN) - 4));
                if ($urandom_range(1)) step = -step;
            end else begin
                walk_pos = int'($urandom_range(int'(FULL_TURN) - 1));
            end
            walk_pos = (walk_pos + step) & int'(FULL_TURN - 1);
            push_angle(walk_pos);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_CAL_MESSAGES, 24'd2);
        // two bias captures, then half-turn steps that are not wraps, then wraps
        push_angle(100);
        push_angle(8191);
        push_angle(4095);
        push_angle(8191);
        push_angle(4094);
        push_angle(8191);
        push_angle(0);
        push_angle(8191);
        push_angle(0);
        push_angle(0);
        // slow backward drift: block mean of -1.5 truncates to -1
        push_angle(8191);
        push_angle(8190);
        push_angle(8189);
        push_angle(8188);
        push_angle(8187);
        push_angle(8186);
        push_angle(8185);
        push_angle(8180);
        drain();
        write_reg(CFG_DEG_PER_COUNT, 24'd0);
        push_angle(0);
        push_angle(8191);
        push_angle(4000);
        drain();
        write_reg(CFG_DEG_PER_COUNT, 24'hFFFFFF);
        push_angle(8191);
        push_angle(0);
        push_angle(1);
        drain();
        write_reg(CFG_DEG_PER_COUNT, 24'd1);
        push_angle(4096);
        push_angle(12);
        drain();

        // calibration resumes while the message count is still low
        write_reg(CFG_CAL_MESSAGES, 24'd100);
        write_reg(CFG_DEG_PER_COUNT, CFG_DATA_W'($urandom_range(24'hFFFFFF, 1)));
        run_walk(150, 120);
        drain();
        write_reg(CFG_CAL_MESSAGES, 24'd255);
        write_reg(CFG_DEG_PER_COUNT, DEF_DEG_PER_COUNT);
        run_walk(150, -90);
        drain();
        write_reg(CFG_CAL_MESSAGES, 24'd0);
        write_reg(CFG_DEG_PER_COUNT, 24'hFFFFFF);
        calm = 1'b1;
        run_walk(200, 200);
        drain();
        calm = 1'b0;
        write_reg(CFG_CAL_MESSAGES, CFG_DATA_W'($urandom_range(255)));
        write_reg(CFG_DEG_PER_COUNT, 24'd1);
        run_walk(150, -250);
        drain();
        write_reg(CFG_CAL_MESSAGES, CFG_DATA_W'(DEF_CAL_MESSAGES));
        write_reg(CFG_DEG_PER_COUNT, CFG_DATA_W'($urandom_range(24'hFFFFFF, 1)));
        run_walk(150, 0);
        drain();
        repeat (10) @(posedge clk);

        if (err_cnt == 0 && tracker_results_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
